@@ rtl/core/tsor_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tsor_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] CMD_PKT  = 2'd0;
    localparam logic [1:0] CMD_CKPT = 2'd1;
    localparam logic [1:0] CMD_FAIL = 2'd2;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_ACK = 8'h10;
    localparam logic [7:0] FL_SA  = FL_ACK | FL_SYN;
    localparam logic [7:0] FL_AF  = FL_ACK | FL_FIN;

    localparam logic [2:0] PH_CLOSED       = 3'd0;
    localparam logic [2:0] PH_SYN_SENT     = 3'd1;
    localparam logic [2:0] PH_SYN_RECEIVED = 3'd2;
    localparam logic [2:0] PH_ESTABLISHED  = 3'd3;
    localparam logic [2:0] PH_CLOSE_WAIT   = 3'd4;
    localparam logic [2:0] PH_FIN_WAIT_1   = 3'd5;
    localparam logic [2:0] PH_LAST_ACK     = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        from_primary;
        logic [7:0]  tcp_flags;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } tsor_in_t;

    typedef struct packed {
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic        csum_redo;
        logic        untracked;
        logic        table_full;
        logic        failover_on;
    } tsor_out_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic        prim;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [63:0] kaddr;
        logic [31:0] kport;
    } tsor_req_t;

endpackage
`default_nettype wire

@@ rtl/core/tsor_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tsor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/tsor_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tsor_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tsor_pkg::tsor_in_t in_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output tsor_pkg::tsor_req_t     q_data,
    output logic                    q_valid,
    input  wire logic               q_ready
);
    import tsor_pkg::*;

    tsor_req_t req_c;
    tsor_req_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    // form the connection key
    always_comb
    begin
        req_c.cmd   = in_data.cmd;
        req_c.prim  = in_data.from_primary;
        req_c.flags = in_data.tcp_flags;
        req_c.seq   = in_data.seq_number;
        req_c.ack   = in_data.ack_number;
        if (in_data.from_primary)
        begin
            req_c.kaddr = {in_data.dst_addr, in_data.src_addr};
            req_c.kport = {in_data.dst_port, in_data.src_port};
        end
        else
        begin
            req_c.kaddr = {in_data.src_addr, in_data.dst_addr};
            req_c.kport = {in_data.src_port, in_data.dst_port};
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = slot_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // two-entry queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= req_c;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/tsor_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tsor_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tsor_pkg::tsor_req_t q_data,
    input  wire logic                q_valid,
    output logic                     q_ready,
    output tsor_pkg::tsor_out_t      out_data,
    output logic                     out_valid,
    input  wire logic                out_ready
);
    import tsor_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam int ROW_W = 64 + 32 + 3 + 32 + 32;

    logic [2:0]  st_reg, st_next;
    tsor_req_t   req_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic        fail_reg;
    logic        hit_reg, free_reg;
    logic [IDX_W-1:0] hidx_reg, fidx_reg;
    logic        nz_reg;
    tsor_out_t   res_reg;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [ROW_W-1:0] wdata, rdata;
    logic [63:0] r_addrs;
    logic [31:0] r_ports, r_off, r_fin;
    logic [2:0]  r_ph;
    logic [IDX_W-1:0] cur;
    logic        cur_v;
    logic        nz_c;

    tsor_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign {r_addrs, r_ports, r_ph, r_off, r_fin} = rdata;
    assign q_ready   = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign out_data  = res_reg;

    // row of the entry read last cycle
    assign cur   = idx_reg[IDX_W-1:0] - IDX_W'(1);
    assign cur_v = valid_reg[cur];

    // nonzero offset seen so far, including the row on the read port
    assign nz_c = nz_reg || (idx_reg != '0 && cur_v && r_off != 32'd0);

    // packet execution on the selected entry
    logic [2:0]  ph;
    logic [31:0] off, fin, seq, ack;
    logic        redo, kill;
    logic [7:0]  sa, af;
    always_comb
    begin
        ph   = hit_reg ? r_ph  : PH_CLOSED;
        off  = hit_reg ? r_off : 32'd0;
        fin  = hit_reg ? r_fin : 32'd0;
        seq  = req_reg.seq;
        ack  = req_reg.ack;
        redo = 1'b0;
        kill = 1'b0;
        sa   = req_reg.flags & FL_SA;
        af   = req_reg.flags & FL_AF;
        if (req_reg.prim)
        begin
            if (sa == FL_SA && ph == PH_SYN_SENT)
            begin
                ph = PH_ESTABLISHED;
            end
            if (sa == FL_SYN)
            begin
                ph = PH_SYN_RECEIVED;
            end
            if (sa == FL_ACK)
            begin
                if (ph == PH_SYN_RECEIVED)
                begin
                    off = off - (ack - 32'd1);
                    ph  = PH_ESTABLISHED;
                end
                if (off != 32'd0)
                begin
                    ack  = ack + off;
                    redo = 1'b1;
                end
                if (ph == PH_LAST_ACK && ack == fin + 32'd1)
                begin
                    kill = 1'b1;
                end
            end
            if (!kill && (req_reg.flags & FL_FIN) != 8'd0)
            begin
                if (ph == PH_ESTABLISHED)
                begin
                    ph = PH_CLOSE_WAIT;
                end
                if (ph == PH_FIN_WAIT_1)
                begin
                    kill = 1'b1;
                end
            end
        end
        else
        begin
            if (ph == PH_SYN_RECEIVED && sa == FL_SA)
            begin
                off = seq;
            end
            if (ph == PH_CLOSED && sa == FL_SYN)
            begin
                ph = PH_SYN_SENT;
            end
            if (sa == FL_ACK && off != 32'd0)
            begin
                seq  = seq - off;
                redo = 1'b1;
            end
            if (ph == PH_CLOSE_WAIT && af == FL_AF)
            begin
                fin = seq;
                ph  = PH_LAST_ACK;
            end
            if (ph == PH_ESTABLISHED && af == FL_FIN)
            begin
                ph = PH_FIN_WAIT_1;
            end
        end
    end

    logic [IDX_W-1:0] eidx;
    logic             track;
    assign eidx  = hit_reg ? hidx_reg : fidx_reg;
    assign track = hit_reg || (!fail_reg && free_reg);

    // memory ports; the sweep writes back the row read last cycle
    always_comb
    begin
        raddr = idx_reg[IDX_W-1:0];
        if (st_reg == ST_READ)
        begin
            raddr = hidx_reg;
        end
        we    = 1'b0;
        waddr = eidx;
        wdata = {req_reg.kaddr, req_reg.kport, ph, off, fin};
        if (st_reg == ST_EXEC && track)
        begin
            we = 1'b1;
        end
        else if (st_reg == ST_SWEEP && req_reg.cmd == CMD_CKPT && idx_reg != '0)
        begin
            we    = 1'b1;
            waddr = cur;
            wdata = {r_addrs, r_ports, r_ph, 32'd0, r_fin};
        end
    end

    // sequencer
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_data.cmd)
                        CMD_PKT:  st_next = ST_SCAN;
                        CMD_CKPT: st_next = ST_SWEEP;
                        CMD_FAIL: st_next = ST_SCAN;
                        default:  st_next = ST_OUT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == CNT_W'(TABLE_ENTRIES))
                begin
                    st_next = (req_reg.cmd == CMD_PKT) ? ST_READ : ST_OUT;
                end
            end
            ST_READ:  st_next = ST_EXEC;
            ST_EXEC:  st_next = ST_OUT;
            ST_SWEEP:
            begin
                if (idx_reg == CNT_W'(TABLE_ENTRIES))
                begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            valid_reg <= '0;
            fail_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                end
                ST_SCAN:
                begin
                    if (idx_reg != CNT_W'(TABLE_ENTRIES))
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else if (req_reg.cmd == CMD_FAIL && !nz_c)
                    begin
                        fail_reg <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    if (track)
                    begin
                        valid_reg[eidx] <= !kill;
                    end
                end
                ST_SWEEP:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // hold request, scan results and result
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE)
        begin
            req_reg  <= q_data;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            nz_reg   <= 1'b0;
            hidx_reg <= '0;
            fidx_reg <= '0;
        end
        if (st_reg == ST_SCAN && idx_reg != '0)
        begin
            if (cur_v)
            begin
                if (!hit_reg && r_addrs == req_reg.kaddr && r_ports == req_reg.kport)
                begin
                    hit_reg  <= 1'b1;
                    hidx_reg <= cur;
                end
                if (r_off != 32'd0)
                begin
                    nz_reg <= 1'b1;
                end
            end
            else if (!free_reg)
            begin
                free_reg <= 1'b1;
                fidx_reg <= cur;
            end
        end
        if (st_reg == ST_EXEC)
        begin
            res_reg.out_seq     <= track ? seq : req_reg.seq;
            res_reg.out_ack     <= track ? ack : req_reg.ack;
            res_reg.csum_redo   <= track && redo;
            res_reg.untracked   <= !track;
            res_reg.table_full  <= !track && !fail_reg;
            res_reg.failover_on <= fail_reg;
        end
        else if (st_reg != ST_OUT && st_next == ST_OUT)
        begin
            res_reg <= tsor_out_t'({67'd0, fail_reg
                || (st_reg == ST_SCAN && req_reg.cmd == CMD_FAIL && !nz_c)});
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/tcp_seq_offset_rewriter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   tsor_in_t
// out      out  out_valid / out_ready tsor_out_t
// A packet holds the back end while it takes the request, scans every row,
// reads the selected row, executes and presents the result.
// Checkpoint sweeps all rows, failover scans them.
// Reset clears valid bits and failover mode; table contents need no clearing.
// A two-entry queue lets the front keep accepting while a result is stalled.
module tcp_seq_offset_rewriter_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tsor_pkg::tsor_in_t  in_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output tsor_pkg::tsor_out_t      out_data,
    output logic                     out_valid,
    input  wire logic                out_ready
);
    import tsor_pkg::*;

    tsor_req_t q_data;
    logic      q_valid, q_ready;

    tsor_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_data   (q_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    tsor_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );
endmodule
`default_nettype wire
